@@ rtl/esc_pkg.sv @@
package esc_pkg;

    localparam int NUM_STAGES = 42;
    localparam int DIV_FIRST  = 15;
    localparam int DIV_LAST   = 30;
    localparam int DIV_STEPS  = 4;

    localparam logic [2:0] REG_ENABLES   = 3'd0;
    localparam logic [2:0] REG_TEMP_CAL  = 3'd1;
    localparam logic [2:0] REG_PRES_LOW  = 3'd2;
    localparam logic [2:0] REG_PRES_HIGH = 3'd3;
    localparam logic [2:0] REG_PRES_LAST = 3'd4;
    localparam logic [2:0] REG_HUM_CAL   = 3'd5;

    localparam logic signed [31:0] TEMP_MIN  = -32'sd4000;
    localparam logic signed [31:0] TEMP_MAX  = 32'sd8500;
    localparam logic [31:0]        PRES_MIN  = 32'd3000000;
    localparam logic [31:0]        PRES_MAX  = 32'd11000000;
    localparam logic signed [31:0] HUM_MAX   = 32'sd419430400;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
        logic        fault_present;
    } esc_in_t;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic signed [31:0] fine_temperature;
        logic [23:0]        pressure_centi_pa;
        logic [16:0]        humidity_q10;
        logic [2:0]         fresh_flags;
    } esc_out_t;

    // partial products of a 64x64 multiply, low 64 bits kept
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] xa;
        logic [31:0] xb;
    } mpp_t;

    typedef struct packed {
        logic [2:0]         en;
        logic [19:0]        rt;
        logic [19:0]        rp;
        logic [15:0]        rh;
        logic signed [31:0] t_d1;
        logic signed [31:0] t_sq;
        logic signed [31:0] t_a;
        logic signed [31:0] t_p3;
        logic signed [31:0] tf;
        logic signed [14:0] tc;
        logic signed [63:0] pv1;
        mpp_t               m_a;
        mpp_t               m_b;
        mpp_t               m_c;
        logic signed [63:0] sq;
        logic signed [63:0] v1p5;
        logic signed [63:0] v1p2;
        logic signed [63:0] x6;
        logic signed [63:0] x3;
        logic signed [63:0] x3t;
        logic signed [63:0] v2;
        logic signed [63:0] v1b;
        logic signed [63:0] num;
        logic signed [31:0] dv;
        logic               dzero;
        logic               dneg;
        logic [31:0]        dd;
        logic [31:0]        dr;
        logic [63:0]        dq;
        logic signed [63:0] v4;
        logic signed [63:0] qq;
        logic signed [63:0] w8;
        logic signed [63:0] a9;
        logic signed [63:0] v2p;
        logic signed [63:0] s;
        logic signed [63:0] v4p;
        logic signed [63:0] pf;
        logic [23:0]        pr;
        logic signed [31:0] hv1;
        logic signed [31:0] h_p4;
        logic signed [31:0] h_p6;
        logic signed [31:0] h_p3;
        logic signed [31:0] h_base;
        logic signed [31:0] h_v5a;
        logic signed [31:0] h_v2;
        logic signed [31:0] h_v3;
        logic signed [31:0] h_v4;
        logic signed [31:0] h_v5;
        logic signed [31:0] h_m;
        logic signed [31:0] h_q;
        logic [16:0]        hr;
    } esc_pipe_t;

    function automatic logic signed [63:0] tdiv64(input logic signed [63:0] x,
                                                   input int unsigned k);
        logic signed [63:0] bias;
        bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (x + bias) >>> k;
    endfunction

    function automatic logic signed [31:0] tdiv32(input logic signed [31:0] x,
                                                   input int unsigned k);
        logic signed [31:0] bias;
        bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
        return (x + bias) >>> k;
    endfunction

    function automatic mpp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
        mpp_t r;
        r.ll = a[31:0] * b[31:0];
        r.xa = a[63:32] * b[31:0];
        r.xb = a[31:0] * b[63:32];
        return r;
    endfunction

    function automatic logic [63:0] mul_sum(input mpp_t p);
        return p.ll + {p.xa + p.xb, 32'b0};
    endfunction

endpackage

@@ rtl/env_sensor_compensation_core.sv @@
// A word accepted at a clock edge is captured by stage 0 at that edge, passes
// through the 41 further pipeline stages and then the output register, and shows
// on result, strobed by result_valid.
// Throughput: one word per cycle; busy stays low and the receiver cannot stall.
// The 64-bit pressure division runs as a 16-stage pipeline retiring 4 quotient bits per stage.
// Reset (rst_n low, asynchronous) clears all valid bits and calibration.
module env_sensor_compensation_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  esc_pkg::esc_in_t item,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [63:0]     cfg_data,
    output logic            result_valid,
    output esc_pkg::esc_out_t result
);
    import esc_pkg::*;

    logic [2:0]  en_reg;
    logic [47:0] tcal_reg;
    logic [63:0] plow_reg;
    logic [63:0] phigh_reg;
    logic [15:0] plast_reg;
    logic [63:0] hcal_reg;

    esc_pipe_t st_reg  [NUM_STAGES];
    esc_pipe_t st_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic     result_valid_reg;
    esc_out_t result_reg;
    esc_out_t result_next;

    logic signed [31:0] t1, t2, t3;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [31:0] h1, h2, h3, h4, h5, h6;

    assign busy         = 1'b0;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign t1 = $signed({16'b0, tcal_reg[15:0]});
    assign t2 = $signed({{16{tcal_reg[31]}}, tcal_reg[31:16]});
    assign t3 = $signed({{16{tcal_reg[47]}}, tcal_reg[47:32]});
    assign p1 = $signed({48'b0, plow_reg[15:0]});
    assign p2 = $signed({{48{plow_reg[31]}}, plow_reg[31:16]});
    assign p3 = $signed({{48{plow_reg[47]}}, plow_reg[47:32]});
    assign p4 = $signed({{48{plow_reg[63]}}, plow_reg[63:48]});
    assign p5 = $signed({{48{phigh_reg[15]}}, phigh_reg[15:0]});
    assign p6 = $signed({{48{phigh_reg[31]}}, phigh_reg[31:16]});
    assign p7 = $signed({{48{phigh_reg[47]}}, phigh_reg[47:32]});
    assign p8 = $signed({{48{phigh_reg[63]}}, phigh_reg[63:48]});
    assign p9 = $signed({{48{plast_reg[15]}}, plast_reg});
    assign h1 = $signed({24'b0, hcal_reg[7:0]});
    assign h2 = $signed({{16{hcal_reg[23]}}, hcal_reg[23:8]});
    assign h3 = $signed({24'b0, hcal_reg[31:24]});
    assign h4 = $signed({{20{hcal_reg[43]}}, hcal_reg[43:32]});
    assign h5 = $signed({{20{hcal_reg[55]}}, hcal_reg[55:44]});
    assign h6 = $signed({{24{hcal_reg[63]}}, hcal_reg[63:56]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg    <= '0;
            tcal_reg  <= '0;
            plow_reg  <= '0;
            phigh_reg <= '0;
            plast_reg <= '0;
            hcal_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ENABLES:   en_reg    <= cfg_data[2:0];
                REG_TEMP_CAL:  tcal_reg  <= cfg_data[47:0];
                REG_PRES_LOW:  plow_reg  <= cfg_data;
                REG_PRES_HIGH: phigh_reg <= cfg_data;
                REG_PRES_LAST: plast_reg <= cfg_data[15:0];
                REG_HUM_CAL:   hcal_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        esc_pipe_t c;
        esc_pipe_t n;
        logic signed [31:0] tv1, tv2, tx, tt, hv;
        logic [32:0] rr;
        logic qbit;
        logic [31:0] pu;

        tv1  = '0;
        tv2  = '0;
        tx   = '0;
        tt   = '0;
        hv   = '0;
        rr   = '0;
        qbit = 1'b0;
        pu   = '0;

        st_next[0]    = '0;
        st_next[0].en = (!item.fault_present && en_reg != 3'd0) ? en_reg : 3'd0;
        st_next[0].rt = item.raw_temperature;
        st_next[0].rp = item.raw_pressure;
        st_next[0].rh = item.raw_humidity;

        for (int k = 1; k < NUM_STAGES; k++)
        begin
            c = st_reg[k-1];
            n = c;
            if (k >= DIV_FIRST && k <= DIV_LAST)
            begin
                for (int b = 0; b < DIV_STEPS; b++)
                begin
                    rr = {n.dr, n.dq[63]};
                    qbit = 1'b0;
                    if (rr >= {1'b0, n.dd})
                    begin
                        rr = rr - {1'b0, n.dd};
                        qbit = 1'b1;
                    end
                    n.dr = rr[31:0];
                    n.dq = {n.dq[62:0], qbit};
                end
            end
            case (k)
                1:
                begin
                    tv1 = $signed({15'b0, c.rt[19:3]})
                        - $signed({15'b0, tcal_reg[15:0], 1'b0});
                    tv2 = $signed({16'b0, c.rt[19:4]}) - t1;
                    n.t_d1 = tv1 * t2;
                    n.t_sq = tv2 * tv2;
                end
                2:
                begin
                    n.t_a  = tdiv32(c.t_d1, 11);
                    n.t_p3 = tdiv32(c.t_sq, 12) * t3;
                end
                3: n.tf = c.t_a + tdiv32(c.t_p3, 14);
                4:
                begin
                    tx = c.tf + (c.tf <<< 2) + 32'sd128;
                    tt = tdiv32(tx, 8);
                    if (tt < TEMP_MIN)
                        tt = TEMP_MIN;
                    else if (tt > TEMP_MAX)
                        tt = TEMP_MAX;
                    n.tc  = tt[14:0];
                    n.pv1 = $signed({{32{c.tf[31]}}, c.tf}) - 64'sd128000;
                    n.hv1 = c.tf - 32'sd76800;
                end
                5:
                begin
                    n.m_a    = mul_pp(c.pv1, c.pv1);
                    n.m_b    = mul_pp(c.pv1, p5);
                    n.m_c    = mul_pp(c.pv1, p2);
                    n.h_p4   = c.hv1 * h5;
                    n.h_p6   = c.hv1 * h6;
                    n.h_p3   = c.hv1 * h3;
                    n.h_base = $signed({2'b0, c.rh, 14'b0}) - (h4 <<< 20);
                end
                6:
                begin
                    n.sq    = $signed(mul_sum(c.m_a));
                    n.v1p5  = $signed(mul_sum(c.m_b));
                    n.v1p2  = $signed(mul_sum(c.m_c));
                    n.h_v5a = c.h_base - c.h_p4 + 32'sd16384;
                    n.h_v2  = tdiv32(c.h_p6, 10);
                    n.h_v3  = tdiv32(c.h_p3, 11) + 32'sd32768;
                end
                7:
                begin
                    n.m_a  = mul_pp(c.sq, p6);
                    n.m_b  = mul_pp(c.sq, p3);
                    n.h_v5 = tdiv32(c.h_v5a, 15);
                    n.h_m  = c.h_v2 * c.h_v3;
                end
                8:
                begin
                    n.x6   = $signed(mul_sum(c.m_a));
                    n.x3   = $signed(mul_sum(c.m_b));
                    n.h_v4 = tdiv32(c.h_m, 10) + 32'sd2097152;
                end
                9:
                begin
                    n.v2  = c.x6 + (c.v1p5 <<< 17);
                    n.x3t = tdiv64(c.x3, 8);
                    n.h_m = c.h_v4 * h2;
                end
                10:
                begin
                    n.v2   = c.v2 + (p4 <<< 35);
                    n.v1b  = c.x3t + (c.v1p2 <<< 12) + 64'sh0000_8000_0000_0000;
                    n.h_v2 = tdiv32(c.h_m + 32'sd8192, 14);
                end
                11:
                begin
                    n.m_a  = mul_pp(c.v1b, p1);
                    n.num  = ((64'sd1048576 - $signed({44'b0, c.rp})) <<< 31) - c.v2;
                    n.h_v3 = c.h_v5 * c.h_v2;
                end
                12:
                begin
                    n.pf  = $signed(mul_sum(c.m_a));
                    n.m_b = mul_pp(c.num, 64'd3125);
                    n.h_q = tdiv32(c.h_v3, 15);
                end
                13:
                begin
                    n.dv  = 32'(tdiv64(c.pf, 33));
                    n.num = $signed(mul_sum(c.m_b));
                    n.h_m = c.h_q * c.h_q;
                end
                14:
                begin
                    n.dzero = (c.dv == 32'sd0);
                    n.dneg  = c.num[63] ^ c.dv[31];
                    n.dq    = c.num[63] ? 64'(-c.num) : 64'(c.num);
                    n.dd    = c.dv[31] ? 32'(-c.dv) : 32'(c.dv);
                    n.dr    = '0;
                    n.h_v4  = tdiv32(c.h_m, 7);
                end
                15: n.h_m = c.h_v4 * h1;
                16: n.h_v5 = c.h_v3 - tdiv32(c.h_m, 4);
                17:
                begin
                    hv = c.h_v5;
                    if (hv < 32'sd0)
                        hv = 32'sd0;
                    if (hv > HUM_MAX)
                        hv = HUM_MAX;
                    n.hr = hv[28:12];
                end
                31: n.v4 = c.dneg ? -$signed(c.dq) : $signed(c.dq);
                32:
                begin
                    n.qq  = tdiv64(c.v4, 13);
                    n.m_a = mul_pp(p8, c.v4);
                end
                33:
                begin
                    n.m_b = mul_pp(p9, c.qq);
                    n.w8  = $signed(mul_sum(c.m_a));
                end
                34:
                begin
                    n.a9  = $signed(mul_sum(c.m_b));
                    n.v2p = tdiv64(c.w8, 19);
                end
                35:
                begin
                    n.m_a = mul_pp(c.a9, c.qq);
                    n.s   = c.v4 + c.v2p;
                end
                36: n.a9 = $signed(mul_sum(c.m_a));
                37: n.s = c.s + tdiv64(c.a9, 25);
                38: n.v4p = tdiv64(c.s, 8) + (p7 <<< 4);
                39: n.m_a = mul_pp(tdiv64(c.v4p, 1), 64'd100);
                40: n.pf = $signed(mul_sum(c.m_a));
                41:
                begin
                    pu = 32'(tdiv64(c.pf, 7));
                    if (pu < PRES_MIN)
                        pu = PRES_MIN;
                    else if (pu > PRES_MAX)
                        pu = PRES_MAX;
                    if (c.dzero)
                        pu = PRES_MIN;
                    n.pr = pu[23:0];
                end
                default: ;
            endcase
            st_next[k] = n;
        end
    end

    always_comb
    begin
        vld_next = {vld_reg[NUM_STAGES-2:0], start && !busy};
    end

    always_comb
    begin
        esc_pipe_t f;
        f = st_reg[NUM_STAGES-1];
        result_next.temperature_centi = f.en[0] ? f.tc : '0;
        result_next.fine_temperature  = (f.en != 3'd0) ? f.tf : '0;
        result_next.pressure_centi_pa = f.en[1] ? f.pr : '0;
        result_next.humidity_q10      = f.en[2] ? f.hr : '0;
        result_next.fresh_flags       = f.en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg          <= vld_next;
            result_valid_reg <= vld_reg[NUM_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            st_reg[k] <= st_next[k];
        end
        result_reg <= result_next;
    end

endmodule

@@ tb/esc_checker.sv @@
`timescale 1ns / 100ps

module esc_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  esc_pkg::esc_in_t    item,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                result_valid,
    input  esc_pkg::esc_out_t   result,
    output int                  fail_count,
    output int                  pending,
    output int                  words_checked
);
    import esc_pkg::*;

    logic [2:0]  en_r;
    logic [47:0] tcal_r;
    logic [63:0] plow_r;
    logic [63:0] phigh_r;
    logic [15:0] plast_r;
    logic [63:0] hcal_r;

    esc_out_t expected_words[$];

    function automatic longint tdiv(longint a, longint b);
        if (b == 0)
            return 0;
        if (b == -1)
            return -a;
        return a / b;
    endfunction

    function automatic int calc_fine(logic [19:0] raw);
        int t1, t2, t3, a, b;
        t1 = tcal_r[15:0];
        t2 = $signed(tcal_r[31:16]);
        t3 = $signed(tcal_r[47:32]);
        a = int'(raw >> 3) - t1 * 2;
        a = (a * t2) / 2048;
        b = int'(raw >> 4) - t1;
        b = (((b * b) / 4096) * t3) / 16384;
        return a + b;
    endfunction

    function automatic logic [31:0] calc_pressure(int tf, logic [19:0] raw);
        longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, v4, q;
        logic [31:0] p;
        p1 = plow_r[15:0];
        p2 = $signed(plow_r[31:16]);
        p3 = $signed(plow_r[47:32]);
        p4 = $signed(plow_r[63:48]);
        p5 = $signed(phigh_r[15:0]);
        p6 = $signed(phigh_r[31:16]);
        p7 = $signed(phigh_r[47:32]);
        p8 = $signed(phigh_r[63:48]);
        p9 = $signed(plast_r);
        v1 = longint'(tf) - 128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + v1 * p5 * 131072;
        v2 = v2 + p4 * 64'sd34359738368;
        v1 = tdiv(v1 * v1 * p3, 256) + v1 * p2 * 4096;
        v1 = tdiv((64'sd140737488355328 + v1) * p1, 64'sd8589934592);
        if (v1 == 0)
            return PRES_MIN;
        v4 = 1048576 - longint'(raw);
        v4 = tdiv((v4 * 64'sd2147483648 - v2) * 3125, v1);
        q = tdiv(v4, 8192);
        v1 = tdiv(p9 * q * q, 33554432);
        v2 = tdiv(p8 * v4, 524288);
        v4 = tdiv(v4 + v1 + v2, 256) + p7 * 16;
        p = 32'(tdiv(tdiv(v4, 2) * 100, 128));
        if (p < PRES_MIN)
            p = PRES_MIN;
        else if (p > PRES_MAX)
            p = PRES_MAX;
        return p;
    endfunction

    function automatic int calc_humidity(int tf, logic [15:0] raw);
        int h1, h2, h3, h4, h5, h6, v1, v2, v3, v4, v5;
        h1 = hcal_r[7:0];
        h2 = $signed(hcal_r[23:8]);
        h3 = hcal_r[31:24];
        h4 = $signed(hcal_r[43:32]);
        h5 = $signed(hcal_r[55:44]);
        h6 = $signed(hcal_r[63:56]);
        v1 = tf - 76800;
        v2 = int'(raw) * 16384;
        v3 = h4 * 1048576;
        v4 = h5 * v1;
        v5 = (v2 - v3 - v4 + 16384) / 32768;
        v2 = (v1 * h6) / 1024;
        v3 = (v1 * h3) / 2048;
        v4 = (v2 * (v3 + 32768)) / 1024 + 2097152;
        v2 = (v4 * h2 + 8192) / 16384;
        v3 = v5 * v2;
        v4 = ((v3 / 32768) * (v3 / 32768)) / 128;
        v5 = v3 - (v4 * h1) / 16;
        if (v5 < 0)
            v5 = 0;
        if (v5 > HUM_MAX)
            v5 = HUM_MAX;
        v5 = v5 / 4096;
        if (v5 > 102400)
            v5 = 102400;
        return v5;
    endfunction

    function automatic esc_out_t compensate(esc_in_t w);
        esc_out_t o;
        int tf, t;
        o = '0;
        if (!w.fault_present && en_r != 0)
        begin
            tf = calc_fine(w.raw_temperature);
            o.fine_temperature = tf;
            if (en_r[0])
            begin
                t = (tf * 5 + 128) / 256;
                if (t < TEMP_MIN)
                    t = TEMP_MIN;
                else if (t > TEMP_MAX)
                    t = TEMP_MAX;
                o.temperature_centi = t[14:0];
                o.fresh_flags[0] = 1'b1;
            end
            if (en_r[1])
            begin
                o.pressure_centi_pa = 24'(calc_pressure(tf, w.raw_pressure));
                o.fresh_flags[1] = 1'b1;
            end
            if (en_r[2])
            begin
                o.humidity_q10 = 17'(calc_humidity(tf, w.raw_humidity));
                o.fresh_flags[2] = 1'b1;
            end
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        esc_out_t e;
        if (!rst_n)
        begin
            en_r          <= '0;
            tcal_r        <= '0;
            plow_r        <= '0;
            phigh_r       <= '0;
            plast_r       <= '0;
            hcal_r        <= '0;
            fail_count    <= 0;
            words_checked <= 0;
            pending       <= 0;
            expected_words.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ENABLES:   en_r    <= cfg_data[2:0];
                    REG_TEMP_CAL:  tcal_r  <= cfg_data[47:0];
                    REG_PRES_LOW:  plow_r  <= cfg_data;
                    REG_PRES_HIGH: phigh_r <= cfg_data;
                    REG_PRES_LAST: plast_r <= cfg_data[15:0];
                    REG_HUM_CAL:   hcal_r  <= cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_words.push_back(compensate(item));
            if (result_valid)
            begin
                words_checked <= words_checked + 1;
                if (expected_words.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result word %h", $realtime, result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (e !== result)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: mismatch exp t=%0d tf=%0d p=%0d h=%0d f=%b",
                                     $realtime, e.temperature_centi, e.fine_temperature,
                                     e.pressure_centi_pa, e.humidity_q10, e.fresh_flags);
                            $display("%0t:          got t=%0d tf=%0d p=%0d h=%0d f=%b",
                                     $realtime, result.temperature_centi,
                                     result.fine_temperature, result.pressure_centi_pa,
                                     result.humidity_q10, result.fresh_flags);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_words.size();
        end
    end

endmodule

@@ tb/tb_env_sensor_compensation_core.sv @@
`timescale 1ns / 100ps

module tb_env_sensor_compensation_core;
    import esc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    esc_in_t     item = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        result_valid;
    esc_out_t    result;
    int          fail_count;
    int          pending;
    int          words_checked;
    int          words_sent;
    int          idle_pct;

    localparam logic [47:0] TYP_TEMP  = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] TYP_PLOW  = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] TYP_PHIGH = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [15:0] TYP_PLAST = 16'd6000;
    localparam logic [63:0] TYP_HUM   = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

    env_sensor_compensation_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .result(result)
    );

    esc_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .result(result),
        .fail_count(fail_count), .pending(pending), .words_checked(words_checked)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("timeout");
        $display("env_sensor_compensation_core verification failed");
        $finish;
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic load_cal(logic [2:0] en, logic [47:0] tc, logic [63:0] pl,
                            logic [63:0] ph, logic [15:0] plast, logic [63:0] hc);
        drain();
        write_reg(REG_ENABLES, {61'd0, en});
        write_reg(REG_TEMP_CAL, {16'd0, tc});
        write_reg(REG_PRES_LOW, pl);
        write_reg(REG_PRES_HIGH, ph);
        write_reg(REG_PRES_LAST, {48'd0, plast});
        write_reg(REG_HUM_CAL, hc);
    endtask

    task automatic send_word(esc_in_t w);
        start <= 1'b1;
        item  <= w;
        do @(posedge clk); while (busy);
        words_sent++;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic esc_in_t mk(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh,
                                   logic f);
        esc_in_t w;
        w.raw_temperature = rt;
        w.raw_pressure    = rp;
        w.raw_humidity    = rh;
        w.fault_present   = f;
        return w;
    endfunction

    function automatic logic [63:0] jitter(logic [63:0] v, int bits);
        logic [63:0] r;
        r = {$urandom, $urandom};
        for (int i = 0; i < 64; i += 16)
            v[i +: 16] = v[i +: 16] + 16'(int'(r[i +: 8] % (1 << bits)) - (1 << (bits - 1)));
        return v;
    endfunction

    function automatic esc_in_t rand_word();
        esc_in_t w;
        if ($urandom_range(9) == 0)
        begin
            w = mk(20'($urandom), 20'($urandom), 16'($urandom), 1'b0);
        end
        else
        begin
            w = mk(20'($urandom_range(380000, 660000)), 20'($urandom_range(200000, 600000)),
                   16'($urandom_range(15000, 50000)), 1'b0);
        end
        w.fault_present = ($urandom_range(19) == 0);
        return w;
    endfunction

    initial
    begin
        logic [2:0] en;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at reset values
        idle_pct = 25;
        send_word(mk(20'd519888, 20'd415148, 16'd30000, 1'b0));

        load_cal(3'd7, TYP_TEMP, TYP_PLOW, TYP_PHIGH, TYP_PLAST, TYP_HUM);
        send_word(mk(20'd519888, 20'd415148, 16'd30000, 1'b0));
        send_word(mk(20'd0, 20'd0, 16'd0, 1'b0));
        send_word(mk(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0));
        send_word(mk(20'hFFFFF, 20'd0, 16'hFFFF, 1'b0));
        send_word(mk(20'd0, 20'hFFFFF, 16'd0, 1'b0));
        send_word(mk(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1));
        send_word(mk(20'd300000, 20'd600000, 16'd60000, 1'b0));
        send_word(mk(20'd700000, 20'd100000, 16'd5000, 1'b0));

        for (int e = 0; e < 8; e++)
        begin
            load_cal(3'(e), TYP_TEMP, TYP_PLOW, TYP_PHIGH, TYP_PLAST, TYP_HUM);
            send_word(mk(20'd519888, 20'd415148, 16'd30000, 1'b0));
            send_word(mk(20'd560000, 20'd300000, 16'd45000, e == 3));
        end

        // zero pressure divisor
        load_cal(3'd7, TYP_TEMP, {TYP_PLOW[63:16], 16'd0}, TYP_PHIGH, TYP_PLAST, TYP_HUM);
        send_word(mk(20'd519888, 20'd415148, 16'd30000, 1'b0));
        // extreme calibration words
        load_cal(3'd7, '1, '1, '1, 16'h8000, '1);
        send_word(mk(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0));
        load_cal(3'd7, {16'h7FFF, 16'h8000, 16'hFFFF}, 64'h8000_7FFF_8000_FFFF,
                 64'h7FFF_8000_7FFF_8000, 16'h7FFF, 64'h7F80_07FF_00FF_80FF);
        send_word(mk(20'd0, 20'd0, 16'd0, 1'b0));
        send_word(mk(20'd1048575, 20'd12345, 16'd65535, 1'b0));

        for (int ph = 0; ph < 18; ph++)
        begin
            idle_pct = ph < 6 ? 25 : ph < 12 ? 77 : 0;
            en = (ph % 4 == 0) ? 3'($urandom) : 3'd7;
            case ($urandom_range(3))
                0: load_cal(en, {$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, 16'($urandom), {$urandom, $urandom});
                1: load_cal(en, TYP_TEMP, TYP_PLOW, TYP_PHIGH, TYP_PLAST, TYP_HUM);
                default: load_cal(en, 48'(jitter({16'd0, TYP_TEMP}, 6)),
                                  jitter(TYP_PLOW, 6), jitter(TYP_PHIGH, 4),
                                  TYP_PLAST + 16'($urandom_range(200)) - 16'd100,
                                  jitter(TYP_HUM, 4));
            endcase
            for (int i = 0; i < 100; i++)
                send_word(rand_word());
        end
        start <= 1'b0;

        drain();
        $display("sent %0d words over 30 calibration sets, %0d results compared",
                 words_sent, words_checked);
        if (fail_count == 0)
            $display("env_sensor_compensation_core verification clean");
        else
            $display("env_sensor_compensation_core verification failed");
        $finish;
    end

endmodule

@@ env_sensor_compensation_core.f @@
rtl/esc_pkg.sv
rtl/env_sensor_compensation_core.sv
tb/esc_checker.sv
tb/tb_env_sensor_compensation_core.sv
